[rtl/mbrs_pkg.sv]
// Package for the register-read slave: payload structs and protocol constants.
// Used by all modules under rtl; depends on nothing.
package mbrs_pkg;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [1:0]  bank;
        logic [3:0]  slot;
        logic [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] tx_bytes;
        logic [2:0]  byte_count;
        logic        last_of_response;
    } out_item_t;

    localparam logic        OP_RX        = 1'b0;
    localparam logic        OP_LOAD      = 1'b1;
    localparam logic [1:0]  BANK_RAW     = 2'd0;
    localparam logic [1:0]  BANK_SCALED  = 2'd1;
    localparam logic [1:0]  BANK_PROBE   = 2'd2;
    localparam logic [7:0]  FUNC_HOLDING = 8'd3;
    localparam logic [7:0]  FUNC_INPUT   = 8'd4;
    localparam logic [7:0]  EXC_FUNC     = 8'd1;
    localparam logic [7:0]  EXC_ADDR     = 8'd2;
    localparam logic [7:0]  EXC_QTY      = 8'd3;
    localparam logic [7:0]  EXC_FLAG     = 8'h80;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [16:0] ADDR_LIMIT   = 17'h0FFFF;

    // One byte of the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

endpackage

[rtl/mbrs_packer.sv]
// Byte-to-word packer: gathers response bytes into items of up to four bytes.
// Depends on mbrs_pkg; holds one output register that acts as the skid stage.
module mbrs_packer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic [7:0]         byte_data,
    input  logic               byte_last,
    output logic               byte_stall,
    output logic               valid,
    input  logic               stall,
    output mbrs_pkg::out_item_t out_item
);

    logic [23:0] acc_reg;
    logic [1:0]  cnt_reg;
    logic        valid_reg;
    mbrs_pkg::out_item_t item_reg;

    logic emit;
    logic out_free;

    assign out_free   = !valid_reg || !stall;
    assign emit       = byte_valid && (byte_last || cnt_reg == 2'd3);
    assign byte_stall = emit && !out_free;
    assign valid      = valid_reg;
    assign out_item   = item_reg;

    // Accumulate bytes; flush a word on the fourth byte or the frame's last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall && emit)
                valid_reg <= 1'b1;
            else if (!stall)
                valid_reg <= 1'b0;
            if (byte_valid && !byte_stall)
            begin
                if (emit)
                    cnt_reg <= 2'd0;
                else
                    cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            case (cnt_reg)
                2'd0: acc_reg[23:16] <= byte_data;
                2'd1: acc_reg[15:8]  <= byte_data;
                2'd2: acc_reg[7:0]   <= byte_data;
                default: ;
            endcase
            if (emit)
            begin
                case (cnt_reg)
                    2'd0: item_reg.tx_bytes <= {byte_data, 24'd0};
                    2'd1: item_reg.tx_bytes <= {acc_reg[23:16], byte_data, 16'd0};
                    2'd2: item_reg.tx_bytes <= {acc_reg[23:8], byte_data, 8'd0};
                    default: item_reg.tx_bytes <= {acc_reg, byte_data};
                endcase
                item_reg.byte_count       <= {1'b0, cnt_reg} + 3'd1;
                item_reg.last_of_response <= byte_last;
            end
        end
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (item_reg.byte_count != 3'd0))
        else $error("empty item");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && stall) |=> valid_reg)
        else $error("item dropped under stall");
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && emit) |=> (cnt_reg == 2'd0))
        else $error("count not cleared on flush");

endmodule

[rtl/modbus_rtu_register_read_slave.sv]
// Top level of the register-read slave: receive, checks, table memory, reply sequencer.
// Depends on mbrs_pkg and mbrs_packer.
//
// Usage: in/in_valid/in_stall carry input items (request bytes or value loads);
// out/out_valid/out_stall carry response items of up to four bytes, first byte
// in bits 31..24, last_of_response on the final item of a reply.
// slave_address is written through cfg_we/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. A request
// byte or a load is taken in idle, after which the block passes through a busy
// state and is idle again. On a frame end that earns a reply, the sequencer moves
// the response bytes in order: three header bytes, then per register a fetch state
// to pick up the word read from the value memory (one registered read port) and two
// data bytes, then two CRC bytes; an exception reply has only the header and CRC
// bytes. The CRC is folded in as each byte leaves, and the sequencer holds while the
// packer stalls it. No input item is taken while a reply is in progress.
// Reset clears the receive state, the filler counter and the address
// register to 1; the value memory has one valid bit per entry, so entries
// read as zero until loaded, with no clearing pass.
// When out_stall is high, the finished item waits in the output register and
// the sequencer holds any byte that would complete a new item until it frees.
module modbus_rtu_register_read_slave
#(
    parameter int ANALOG_CHANNELS = 8,
    parameter int PROBES          = 4,
    parameter int MAX_FRAME_BYTES = 256,
    parameter int MAX_QUANTITY    = 125
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mbrs_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output mbrs_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data
);

    localparam int PSLOTS  = 2 * PROBES;
    localparam int DEPTH   = 2 * ANALOG_CHANNELS + PSLOTS;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(MAX_FRAME_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_BUSY, S_HDR, S_FETCH, S_DATA_HI, S_DATA_LO, S_CRC
    } state_t;

    state_t state_reg;
    logic [7:0]      addr_reg;
    logic [7:0]      hdr_reg [6];
    logic [CW-1:0]   count_reg;
    logic [15:0]     rx_crc_reg;
    logic [7:0]      tail_reg [2];
    logic [7:0]      filler_reg;

    // Reply sequencer state
    logic [15:0]     tx_crc_reg;
    logic [1:0]      hdr_idx_reg;
    logic [7:0]      qty_left_reg;
    logic [16:0]     cur_addr_reg;
    logic            exc_reg;
    logic [7:0]      b0_reg, b1_reg, b2_reg;
    logic            crc_hi_reg;
    logic [15:0]     word_reg;
    logic            is_scaled_reg;

    // Value memory and its valid bits
    logic [15:0]     mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [15:0]     rd_data_reg;
    logic            rd_vld_reg;
    logic            rd_filler_reg;

    logic            bvalid, blast, bstall;
    logic [7:0]      bdata;
    logic            accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Load target decode
    logic            ld_ok;
    logic [AW-1:0]   ld_addr;
    always_comb
    begin
        ld_ok   = 1'b0;
        ld_addr = '0;
        case (in_item.bank)
            mbrs_pkg::BANK_RAW:
            begin
                ld_ok   = {1'b0, in_item.slot} < 5'(ANALOG_CHANNELS);
                ld_addr = AW'(in_item.slot);
            end
            mbrs_pkg::BANK_SCALED:
            begin
                ld_ok   = {1'b0, in_item.slot} < 5'(ANALOG_CHANNELS);
                ld_addr = AW'(in_item.slot) + AW'(ANALOG_CHANNELS);
            end
            mbrs_pkg::BANK_PROBE:
            begin
                ld_ok   = {1'b0, in_item.slot} < 5'(PSLOTS);
                ld_addr = AW'(in_item.slot) + AW'(2 * ANALOG_CHANNELS);
            end
            default: ;
        endcase
    end

    // Frame checks at frame end (uses state after this byte)
    logic [15:0] start_w, qty_w;
    logic [16:0] end_w;
    logic        good_frame;
    logic [7:0]  func_w;
    logic [CW-1:0] cnt_new;
    logic [15:0] crc_new;
    logic [7:0]  t0_new, t1_new;
    logic [7:0]  h_new [6];
    logic        take;

    always_comb
    begin
        take    = count_reg < CW'(MAX_FRAME_BYTES);
        cnt_new = count_reg;
        crc_new = rx_crc_reg;
        t0_new  = tail_reg[0];
        t1_new  = tail_reg[1];
        for (int i = 0; i < 6; i++)
            h_new[i] = hdr_reg[i];
        if (take)
        begin
            if (count_reg >= CW'(2))
                crc_new = mbrs_pkg::crc_byte(rx_crc_reg, tail_reg[0]);
            t0_new  = tail_reg[1];
            t1_new  = in_item.rx_byte;
            for (int i = 0; i < 6; i++)
                if (count_reg == CW'(i))
                    h_new[i] = in_item.rx_byte;
            cnt_new = count_reg + CW'(1);
        end
        func_w     = h_new[1];
        start_w    = {h_new[2], h_new[3]};
        qty_w      = {h_new[4], h_new[5]};
        end_w      = {1'b0, start_w} + {1'b0, qty_w};
        good_frame = (cnt_new >= CW'(2)) && (h_new[0] == addr_reg)
                     && ({t1_new, t0_new} == crc_new);
    end

    // Address lookup for the register read
    logic [AW-1:0] rd_addr;
    logic          rd_is_filler;
    always_comb
    begin
        rd_is_filler = 1'b0;
        rd_addr      = '0;
        if (cur_addr_reg < 17'(ANALOG_CHANNELS))
            rd_addr = is_scaled_reg ? AW'(cur_addr_reg) + AW'(ANALOG_CHANNELS)
                                    : AW'(cur_addr_reg);
        else if (cur_addr_reg < 17'(ANALOG_CHANNELS + PSLOTS))
            rd_addr = AW'(cur_addr_reg - 17'(ANALOG_CHANNELS)) + AW'(2 * ANALOG_CHANNELS);
        else
            rd_is_filler = 1'b1;
    end

    // Memory: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && in_item.op == mbrs_pkg::OP_LOAD && ld_ok)
            mem[ld_addr] <= in_item.value;
        rd_data_reg <= mem[rd_addr];
    end

    // Byte to emit from the sequencer
    always_comb
    begin
        bvalid = 1'b0;
        blast  = 1'b0;
        bdata  = 8'd0;
        case (state_reg)
            S_HDR:
            begin
                bvalid = 1'b1;
                case (hdr_idx_reg)
                    2'd0: bdata = b0_reg;
                    2'd1: bdata = b1_reg;
                    default: bdata = b2_reg;
                endcase
            end
            S_DATA_HI:
            begin
                bvalid = 1'b1;
                bdata  = word_reg[15:8];
            end
            S_DATA_LO:
            begin
                bvalid = 1'b1;
                bdata  = word_reg[7:0];
            end
            S_CRC:
            begin
                bvalid = 1'b1;
                bdata  = crc_hi_reg ? tx_crc_reg[15:8] : tx_crc_reg[7:0];
                blast  = crc_hi_reg;
            end
            default: ;
        endcase
    end

    // Control: receive, load, reply sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= 8'd1;
            count_reg    <= '0;
            rx_crc_reg   <= mbrs_pkg::CRC_INIT;
            filler_reg   <= 8'd0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_filler_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                hdr_reg[i] <= 8'd0;
            tail_reg[0]  <= 8'd0;
            tail_reg[1]  <= 8'd0;
            tx_crc_reg   <= mbrs_pkg::CRC_INIT;
            hdr_idx_reg  <= 2'd0;
            qty_left_reg <= 8'd0;
            cur_addr_reg <= '0;
            exc_reg      <= 1'b0;
            b0_reg <= 8'd0; b1_reg <= 8'd0; b2_reg <= 8'd0;
            crc_hi_reg   <= 1'b0;
            word_reg     <= 16'd0;
            is_scaled_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                addr_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_item.op == mbrs_pkg::OP_RX && in_item.frame_end && good_frame)
                            state_reg <= S_HDR;
                        else
                            state_reg <= S_BUSY;
                        if (in_item.op == mbrs_pkg::OP_LOAD)
                        begin
                            if (ld_ok)
                                vld_reg[ld_addr] <= 1'b1;
                        end
                        else if (!in_item.frame_end)
                        begin
                            count_reg  <= cnt_new;
                            rx_crc_reg <= crc_new;
                            tail_reg[0] <= t0_new;
                            tail_reg[1] <= t1_new;
                            for (int i = 0; i < 6; i++)
                                hdr_reg[i] <= h_new[i];
                        end
                        else
                        begin
                            count_reg  <= '0;
                            rx_crc_reg <= mbrs_pkg::CRC_INIT;
                            tail_reg[0] <= 8'd0;
                            tail_reg[1] <= 8'd0;
                            for (int i = 0; i < 6; i++)
                                hdr_reg[i] <= 8'd0;
                            b0_reg        <= addr_reg;
                            tx_crc_reg    <= mbrs_pkg::CRC_INIT;
                            hdr_idx_reg   <= 2'd0;
                            crc_hi_reg    <= 1'b0;
                            is_scaled_reg <= (func_w == mbrs_pkg::FUNC_HOLDING);
                            cur_addr_reg  <= {1'b0, start_w};
                            qty_left_reg  <= qty_w[7:0];
                            if (func_w != mbrs_pkg::FUNC_HOLDING
                                && func_w != mbrs_pkg::FUNC_INPUT)
                            begin
                                exc_reg <= 1'b1;
                                b1_reg  <= mbrs_pkg::EXC_FLAG + func_w;
                                b2_reg  <= mbrs_pkg::EXC_FUNC;
                            end
                            else if (qty_w == 16'd0 || qty_w > 16'(MAX_QUANTITY))
                            begin
                                exc_reg <= 1'b1;
                                b1_reg  <= mbrs_pkg::EXC_FLAG + func_w;
                                b2_reg  <= mbrs_pkg::EXC_QTY;
                            end
                            else if (end_w > mbrs_pkg::ADDR_LIMIT)
                            begin
                                exc_reg <= 1'b1;
                                b1_reg  <= mbrs_pkg::EXC_FLAG + func_w;
                                b2_reg  <= mbrs_pkg::EXC_ADDR;
                            end
                            else
                            begin
                                exc_reg <= 1'b0;
                                b1_reg  <= func_w;
                                b2_reg  <= {qty_w[6:0], 1'b0};
                            end
                        end
                    end
                end
                S_BUSY:
                    state_reg <= S_IDLE;
                S_HDR:
                begin
                    if (!bstall)
                    begin
                        tx_crc_reg  <= mbrs_pkg::crc_byte(tx_crc_reg, bdata);
                        hdr_idx_reg <= hdr_idx_reg + 2'd1;
                        if (hdr_idx_reg == 2'd2)
                        begin
                            if (exc_reg)
                                state_reg <= S_CRC;
                            else
                            begin
                                state_reg     <= S_FETCH;
                                rd_vld_reg    <= vld_reg[rd_addr];
                                rd_filler_reg <= rd_is_filler;
                                if (rd_is_filler)
                                    filler_reg <= filler_reg + 8'd1;
                            end
                        end
                    end
                end
                S_FETCH:
                begin
                    // read data registered last cycle; pick word
                    if (rd_filler_reg)
                        word_reg <= {8'd0, filler_reg};
                    else if (rd_vld_reg)
                        word_reg <= rd_data_reg;
                    else
                        word_reg <= 16'd0;
                    state_reg    <= S_DATA_HI;
                    cur_addr_reg <= cur_addr_reg + 17'd1;
                    qty_left_reg <= qty_left_reg - 8'd1;
                end
                S_DATA_HI:
                begin
                    if (!bstall)
                    begin
                        tx_crc_reg <= mbrs_pkg::crc_byte(tx_crc_reg, bdata);
                        state_reg  <= S_DATA_LO;
                    end
                end
                S_DATA_LO:
                begin
                    if (!bstall)
                    begin
                        tx_crc_reg <= mbrs_pkg::crc_byte(tx_crc_reg, bdata);
                        if (qty_left_reg == 8'd0)
                            state_reg <= S_CRC;
                        else
                        begin
                            state_reg     <= S_FETCH;
                            rd_vld_reg    <= vld_reg[rd_addr];
                            rd_filler_reg <= rd_is_filler;
                            if (rd_is_filler)
                                filler_reg <= filler_reg + 8'd1;
                        end
                    end
                end
                S_CRC:
                begin
                    if (!bstall)
                    begin
                        crc_hi_reg <= 1'b1;
                        if (crc_hi_reg)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    mbrs_packer u_packer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (bvalid),
        .byte_data  (bdata),
        .byte_last  (blast),
        .byte_stall (bstall),
        .valid      (out_valid),
        .stall      (out_stall),
        .out_item   (out_item)
    );

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("item taken during reply");
    a_qty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> (qty_left_reg != 8'd0))
        else $error("register count underflow");
    a_crc_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRC && crc_hi_reg && !bstall) |=> (state_reg == S_IDLE))
        else $error("reply did not close");

endmodule
